// ----- design/bitmap_glyph_point_rasterizer_top_macros.svh -----
// assertion macros for the glyph point rasterizer checker
// expects clk and arst_n in the scope where a macro is used
`ifndef BITMAP_GLYPH_POINT_RASTERIZER_TOP_MACROS_SVH
`define BITMAP_GLYPH_POINT_RASTERIZER_TOP_MACROS_SVH

// property holds at every edge outside reset
`define BGPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// non-overlapping implication from antecedent to consequent
`define BGPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bgpr_pkg.sv -----
// shared types, constants and glyph rom for the glyph point rasterizer
// no dependencies
package bgpr_pkg;

	localparam int ROWS     = 5;
	localparam int COLS     = 3;
	localparam int CELLS    = ROWS * COLS;
	localparam int GLYPHS   = 40;
	localparam int SIZE_DIV = 6;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PIXEL_SIZE = 2'd0,
		REG_ORIGIN_X   = 2'd1,
		REG_ORIGIN_Y   = 2'd2,
		REG_INK_COLOR  = 2'd3
	} cfg_reg_t;

	// special glyph slots
	localparam logic [5:0] GLYPH_DIGIT0  = 6'd26;
	localparam logic [5:0] GLYPH_DASH    = 6'd36;
	localparam logic [5:0] GLYPH_DOT     = 6'd37;
	localparam logic [5:0] GLYPH_SPACE   = 6'd38;
	localparam logic [5:0] GLYPH_UNKNOWN = 6'd39;

	// character codes
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_DASH    = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CASE_FOLD  = 8'd32;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	// one character queued for drawing
	typedef struct packed {
		logic [15:0]      pen_x;
		logic [CELLS-1:0] cells;   // bit row*COLS+col, row 0 col 0 first
	} glyph_job_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// rows of each glyph, bit 2 is the left column
	localparam logic [2:0] GLYPH_ROM [GLYPHS][ROWS] = '{
		'{3'd2,3'd5,3'd7,3'd5,3'd5}, '{3'd6,3'd5,3'd6,3'd5,3'd6},
		'{3'd3,3'd4,3'd4,3'd4,3'd3}, '{3'd6,3'd5,3'd5,3'd5,3'd6},
		'{3'd7,3'd4,3'd6,3'd4,3'd7}, '{3'd7,3'd4,3'd6,3'd4,3'd4},
		'{3'd3,3'd4,3'd5,3'd5,3'd3}, '{3'd5,3'd5,3'd7,3'd5,3'd5},
		'{3'd7,3'd2,3'd2,3'd2,3'd7}, '{3'd1,3'd1,3'd1,3'd5,3'd2},
		'{3'd5,3'd5,3'd6,3'd5,3'd5}, '{3'd4,3'd4,3'd4,3'd4,3'd7},
		'{3'd5,3'd7,3'd7,3'd5,3'd5}, '{3'd5,3'd7,3'd7,3'd7,3'd5},
		'{3'd2,3'd5,3'd5,3'd5,3'd2}, '{3'd6,3'd5,3'd6,3'd4,3'd4},
		'{3'd2,3'd5,3'd5,3'd2,3'd1}, '{3'd6,3'd5,3'd6,3'd5,3'd5},
		'{3'd3,3'd4,3'd2,3'd1,3'd6}, '{3'd7,3'd2,3'd2,3'd2,3'd2},
		'{3'd5,3'd5,3'd5,3'd5,3'd7}, '{3'd5,3'd5,3'd5,3'd5,3'd2},
		'{3'd5,3'd5,3'd7,3'd7,3'd5}, '{3'd5,3'd5,3'd2,3'd5,3'd5},
		'{3'd5,3'd5,3'd2,3'd2,3'd2}, '{3'd7,3'd1,3'd2,3'd4,3'd7},
		'{3'd2,3'd5,3'd5,3'd5,3'd2}, '{3'd2,3'd6,3'd2,3'd2,3'd7},
		'{3'd7,3'd1,3'd7,3'd4,3'd7}, '{3'd7,3'd1,3'd3,3'd1,3'd7},
		'{3'd5,3'd5,3'd7,3'd1,3'd1}, '{3'd7,3'd4,3'd7,3'd1,3'd7},
		'{3'd3,3'd4,3'd7,3'd5,3'd7}, '{3'd7,3'd1,3'd2,3'd2,3'd2},
		'{3'd7,3'd5,3'd7,3'd5,3'd7}, '{3'd7,3'd5,3'd7,3'd1,3'd6},
		'{3'd0,3'd0,3'd7,3'd0,3'd0}, '{3'd0,3'd0,3'd0,3'd0,3'd2},
		'{3'd0,3'd0,3'd0,3'd0,3'd0}, '{3'd7,3'd1,3'd2,3'd0,3'd2}
	};

	// fold to upper case and map a code to its glyph slot
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_FOLD;
		priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 6'(c - CH_UPPER_A);
		else if (c >= CH_ZERO && c <= CH_NINE) return GLYPH_DIGIT0 + 6'(c - CH_ZERO);
		else if (c == CH_DASH)  return GLYPH_DASH;
		else if (c == CH_DOT)   return GLYPH_DOT;
		else if (c == CH_SPACE) return GLYPH_SPACE;
		else return GLYPH_UNKNOWN;
	endfunction

	// lit cells of a glyph in drawing order
	function automatic logic [CELLS-1:0] glyph_cells(input logic [5:0] idx);
		logic [CELLS-1:0] cells;
		cells = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				cells[r*COLS+c] = GLYPH_ROM[idx][r][COLS-1-c];
			end
		end
		return cells;
	endfunction

endpackage

// ----- design/bgpr_queue.sv -----
// two-entry queue of glyph jobs between front and back
// depends on bgpr_pkg
module bgpr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bgpr_pkg::glyph_job_t push_job,
	input  logic                pop,
	output bgpr_pkg::glyph_job_t head_job,
	output bgpr_pkg::queue_status_t status
);
	import bgpr_pkg::*;

	glyph_job_t           mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_job;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_job     = mem[rd_ptr_q];
	assign status.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ----- design/bgpr_front.sv -----
// front end: accepts characters, tracks the pen and looks up glyphs
// depends on bgpr_pkg
module bgpr_front #(
	parameter int MAX_SCALE = 2,
	parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             char_code,
	input  logic                   label_start,
	input  logic [15:0]            origin_x,
	input  logic [SCALE_W-1:0]     scale,
	input  bgpr_pkg::queue_status_t q_status,
	output logic                   push,
	output bgpr_pkg::glyph_job_t   push_job
);
	import bgpr_pkg::*;

	logic [15:0]      pen_q;
	logic [15:0]      pen_now;
	logic [CELLS-1:0] cells;
	logic             accept;

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;

	// pen for this character and its glyph
	assign pen_now = label_start ? origin_x : pen_q;
	assign cells   = glyph_cells(glyph_index(char_code));

	// blank glyphs only move the pen
	assign push           = accept && (cells != '0);
	assign push_job.pen_x = pen_now;
	assign push_job.cells = cells;

	// pen advances by four cells of the current scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= '0;
		end else if (accept) begin
			pen_q <= pen_now + (16'(scale) << 2);
		end
	end

endmodule

// ----- design/bgpr_back.sv -----
// back end: walks the cells of one glyph and emits points
// depends on bgpr_pkg
module bgpr_back #(
	parameter int MAX_SCALE = 2,
	parameter int SCALE_W   = $clog2(MAX_SCALE + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bgpr_pkg::queue_status_t q_status,
	input  bgpr_pkg::glyph_job_t    head_job,
	output logic                    pop,
	input  logic [SCALE_W-1:0]      scale,
	input  logic [15:0]             origin_y,
	input  logic [23:0]             ink_color,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             point_x,
	output logic [15:0]             point_y,
	output logic [23:0]             point_color,
	output logic                    last_point
);
	import bgpr_pkg::*;

	logic [CELLS-1:0]   cells_q;
	logic [15:0]        pen_q;
	logic [1:0]         col_q;
	logic [2:0]         row_q;
	logic [SCALE_W-1:0] dx_q;
	logic [SCALE_W-1:0] dy_q;
	logic               valid_q;
	logic               step;
	logic               lit;
	logic               dx_end;
	logic               dy_end;
	logic               cell_done;
	logic               emit;

	// take the next job once the current glyph is finished
	assign pop = (cells_q == '0) && !q_status.empty;

	// one cell or one point per step, held while the output is stalled
	assign step      = (cells_q != '0) && (!valid_q || m_tready);
	assign lit       = cells_q[0];
	assign dx_end    = (dx_q == scale - SCALE_W'(1));
	assign dy_end    = (dy_q == scale - SCALE_W'(1));
	assign cell_done = !lit || (dx_end && dy_end);
	assign emit      = step && lit;

	// cell walk and sub-point counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
		end else if (pop) begin
			cells_q <= head_job.cells;
			col_q   <= '0;
			row_q   <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
		end else if (step) begin
			if (lit) begin
				dx_q <= dx_end ? '0 : dx_q + SCALE_W'(1);
				if (dx_end) dy_q <= dy_end ? '0 : dy_q + SCALE_W'(1);
			end
			if (cell_done) begin
				cells_q <= cells_q >> 1;
				if (col_q == 2'(COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + 3'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
		end
	end

	// pen of the glyph being drawn
	always_ff @(posedge clk) begin
		if (pop) pen_q <= head_job.pen_x;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			point_x     <= pen_q + 16'(col_q) * 16'(scale) + 16'(dx_q);
			point_y     <= origin_y + 16'(row_q) * 16'(scale) + 16'(dy_q);
			point_color <= ink_color;
			last_point  <= (cells_q[CELLS-1:1] == '0) && dx_end && dy_end;
		end
	end

	assign m_tvalid = valid_q;

endmodule

// ----- design/bitmap_glyph_point_rasterizer_top.sv -----
// top level of the 3x5 bitmap glyph point rasterizer
// depends on bgpr_pkg, bgpr_front, bgpr_queue and bgpr_back
//
// Takes one label character per input item (tuser marks a label start) and
// emits one point per output item, at most one per cycle, with tlast on the
// final point of a character. The front hands each accepted character's
// glyph to a two-entry queue; a blank glyph only moves the pen and reaches
// no further. The back scans the 15 cells of a glyph one per cycle while
// the output is not stalled, up to its last lit cell, draws each lit cell
// as a square of points, scale on a side, and takes the next glyph only
// once the current one is finished. The output register holds a point
// while the sink stalls, and the front keeps accepting until the queue is
// full. Configuration is written through cfg_we / cfg_index / cfg_wdata
// only while the block is idle; this binds the user, it is not enforced.
module bitmap_glyph_point_rasterizer_top #(
	parameter int MAX_SCALE = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic        s_tuser,   // label_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // point_color, point_y, point_x
	output logic        m_tlast    // last_point
);
	import bgpr_pkg::*;

	localparam int SCALE_W = $clog2(MAX_SCALE + 1);

	logic [7:0]         pixel_size_q;
	logic [15:0]        origin_x_q;
	logic [15:0]        origin_y_q;
	logic [23:0]        ink_color_q;
	logic [SCALE_W-1:0] scale;
	logic               push;
	logic               pop;
	glyph_job_t         push_job;
	glyph_job_t         head_job;
	queue_status_t      q_status;
	logic [15:0]        point_x;
	logic [15:0]        point_y;
	logic [23:0]        point_color;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_size_q <= 8'd6;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			ink_color_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PIXEL_SIZE: pixel_size_q <= cfg_wdata[7:0];
				REG_ORIGIN_X:   origin_x_q   <= cfg_wdata[15:0];
				REG_ORIGIN_Y:   origin_y_q   <= cfg_wdata[15:0];
				REG_INK_COLOR:  ink_color_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scale is pixel_size/6 clamped to 1..MAX_SCALE, found by compares
	always_comb begin
		scale = SCALE_W'(1);
		for (int k = 2; k <= MAX_SCALE; k++) begin
			if (pixel_size_q >= 8'(SIZE_DIV * k)) scale = SCALE_W'(k);
		end
	end

	bgpr_front #(.MAX_SCALE(MAX_SCALE), .SCALE_W(SCALE_W)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.char_code   (s_tdata),
		.label_start (s_tuser),
		.origin_x    (origin_x_q),
		.scale       (scale),
		.q_status    (q_status),
		.push        (push),
		.push_job    (push_job)
	);

	bgpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	bgpr_back #(.MAX_SCALE(MAX_SCALE), .SCALE_W(SCALE_W)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head_job    (head_job),
		.pop         (pop),
		.scale       (scale),
		.origin_y    (origin_y_q),
		.ink_color   (ink_color_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_color (point_color),
		.last_point  (m_tlast)
	);

	assign m_tdata = {point_color, point_y, point_x};

endmodule

// ----- design/bgpr_checker.sv -----
// port-level checks for the glyph point rasterizer, bound to the top level
// depends on bitmap_glyph_point_rasterizer_top_macros.svh
`include "bitmap_glyph_point_rasterizer_top_macros.svh"

module bgpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	// a stalled point stays offered
	`BGPR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "point dropped while stalled")

	// a stalled point keeps its payload
	`BGPR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled point changed")

	// queue comes out of reset empty and ready
	`BGPR_ASSERT(a_ready_after_reset, !$past(arst_n) |-> s_tready, "not ready after reset")

	// no point can exist before any character was taken
	`BGPR_ASSERT(a_idle_after_reset, !$past(arst_n) |-> !m_tvalid, "point offered right after reset")

endmodule

bind bitmap_glyph_point_rasterizer_top bgpr_checker u_bgpr_checker (.*);
